FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL modules.
// Every property is sampled on the rising edge of clk and is ignored while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a clocked property and reports a failure with the given message.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: hw/rtl/htwt_pkg.sv
// Shared types and constants for the word-triple name generator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package htwt_pkg;

  // Letter coding of a packed dictionary word.
  localparam int LETTER_BITS  = 5;
  localparam int CODE_BITS    = 60;
  localparam int INDEX_BITS   = 16;
  localparam int SHASH_BITS   = 48;
  // Wide enough to count up to the largest supported word length (12).
  localparam int LETTER_IDX_W = 4;
  // The hash is divided one 16-bit digit at a time.
  localparam int DIGIT_BITS   = 16;

  // Characters of the output name.
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NAME = 1'b1;

  // Index of the last of the three words.
  localparam logic [1:0] LAST_WORD = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_READ,
    ST_SEP,
    ST_LET
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                    load;
    logic                    start;
    logic                    div_mul;
    logic                    div_step;
    logic                    clr_rem;
    logic                    rd;
    logic                    emit_sep;
    logic                    emit_letter;
    logic                    last;
    logic [LETTER_IDX_W-1:0] letter_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic letter_zero;
    logic next_zero;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/htwt_dp.sv
// Datapath of the word-triple name generator: dictionary memory, radix divider,
// letter selection and the output register. Depends on htwt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htwt_dp import htwt_pkg::*; #(
  parameter int DICT_WORDS   = 54413,
  parameter int WORD_LETTERS = 12,
  parameter int HASH_BITS    = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      sts,
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  localparam int IDX_W  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int CHUNKS = (HASH_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int QW     = CHUNKS * DIGIT_BITS;
  // Reciprocal of the dictionary size, scaled by 2^32 and rounded down.
  localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(DICT_WORDS);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [16:0] DIVISOR    = 17'(DICT_WORDS);

  logic [INDEX_BITS-1:0] entry_index;
  logic [CODE_BITS-1:0]  entry_code;
  logic [SHASH_BITS-1:0] req_hash;
  logic [63:0]           hash_ext;
  logic                  in_range;

  logic [CODE_BITS-1:0]  dict_mem [DICT_WORDS];
  logic [CODE_BITS-1:0]  rd_data;

  logic [QW-1:0]         quo;
  logic [IDX_W-1:0]      rem;
  logic [31:0]           dvd;
  logic [63:0]           prod;
  logic [DIGIT_BITS-1:0] q_est;
  logic [32:0]           qn;
  logic [32:0]           r_est;
  logic                  ge;
  logic [32:0]           r_fix;
  logic [DIGIT_BITS-1:0] q_dig;
  logic [IDX_W-1:0]      rem_next;
  logic [QW-1:0]         quo_next;

  logic [LETTER_BITS-1:0] cur_letter;
  logic [LETTER_BITS-1:0] nxt_letter;

  // Unpack the input payload.
  assign entry_index = s_tdata[15:0];
  assign entry_code  = s_tdata[75:16];
  assign req_hash    = s_tdata[123:76];
  assign hash_ext    = {16'b0, req_hash};
  assign in_range    = {1'b0, entry_index} < (INDEX_BITS + 1)'(DICT_WORDS);

  // Dictionary store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      dict_mem[entry_index[IDX_W-1:0]] <= entry_code;
    end
    if (cmd.rd) begin
      rd_data <= dict_mem[rem];
    end
  end

  // Partial dividend: running remainder above the next 16-bit digit of the hash.
  assign dvd  = 32'({rem, quo[QW-1 -: DIGIT_BITS]});
  // Quotient digit estimate; it is exact or one too small.
  assign prod = 64'(dvd) * 64'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_mul) begin
      q_est <= prod[32 +: DIGIT_BITS];
    end
  end

  // Correction step: one compare and subtract fixes the estimate.
  always_comb begin
    qn       = {17'b0, q_est} * {16'b0, DIVISOR};
    r_est    = {1'b0, dvd} - qn;
    ge       = r_est >= {16'b0, DIVISOR};
    r_fix    = ge ? r_est - {16'b0, DIVISOR} : r_est;
    rem_next = r_fix[IDX_W-1:0];
    q_dig    = q_est + DIGIT_BITS'(ge);
    quo_next = QW'({quo, q_dig});
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo <= QW'(hash_ext[HASH_BITS-1:0]);
      rem <= '0;
    end else if (cmd.clr_rem) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // Current and following letter of the word; past the end reads as zero.
  always_comb begin
    cur_letter = '0;
    nxt_letter = '0;
    for (int i = 0; i < WORD_LETTERS; i++) begin
      if (cmd.letter_idx == LETTER_IDX_W'(i)) begin
        cur_letter = rd_data[(WORD_LETTERS - 1 - i) * LETTER_BITS +: LETTER_BITS];
      end
    end
    for (int i = 0; i < WORD_LETTERS - 1; i++) begin
      if (cmd.letter_idx == LETTER_IDX_W'(i)) begin
        nxt_letter = rd_data[(WORD_LETTERS - 2 - i) * LETTER_BITS +: LETTER_BITS];
      end
    end
  end

  assign sts.letter_zero = (cur_letter == '0);
  assign sts.next_zero   = (nxt_letter == '0);
  assign sts.out_free    = !m_tvalid || m_tready;

  // Output register; a new character is loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_sep || cmd.emit_letter) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sep) begin
      m_tdata <= CHAR_UNDER;
      m_tlast <= cmd.last;
    end else if (cmd.emit_letter) begin
      m_tdata <= CHAR_A - 8'd1 + {3'b0, cur_letter};
      m_tlast <= cmd.last;
    end
  end

  // A character must never overwrite one that has not been transferred.
  `ASSERT_CLK(a_emit_free, (cmd.emit_sep || cmd.emit_letter) |-> sts.out_free,
              "character emitted while output register is occupied")
  // A letter is never the terminating zero group.
  `ASSERT_CLK(a_letter_nonzero, cmd.emit_letter |-> !sts.letter_zero,
              "zero letter group emitted as a character")
  // The divider never works while a word is being read or emitted.
  `ASSERT_NEVER(a_div_quiet, (cmd.div_step || cmd.div_mul) && (cmd.rd || cmd.emit_sep || cmd.emit_letter),
                "divider stepped during word output")

endmodule

FILE: hw/rtl/htwt_ctrl.sv
// Controller of the word-triple name generator: sequences the division, the
// dictionary reads and the character output. Depends on htwt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htwt_ctrl import htwt_pkg::*; #(
  parameter int WORD_LETTERS = 12,
  parameter int HASH_BITS    = 48
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    s_tuser,
  output cmd_t    cmd,
  input  status_t sts
);

  localparam int CHUNKS = (HASH_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BC_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  state_t                  state, state_next;
  logic [BC_W-1:0]         bit_cnt, bit_cnt_next;
  logic [1:0]              word, word_next;
  logic [LETTER_IDX_W-1:0] letter_idx, letter_idx_next;
  logic                    word_end;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bit_cnt    <= '0;
      word       <= '0;
      letter_idx <= '0;
    end else begin
      state      <= state_next;
      bit_cnt    <= bit_cnt_next;
      word       <= word_next;
      letter_idx <= letter_idx_next;
    end
  end

  // A word ends at its first zero group or after its last letter.
  assign word_end = sts.letter_zero || (letter_idx == LETTER_IDX_W'(WORD_LETTERS));

  // Next state and commands.
  always_comb begin
    state_next      = state;
    bit_cnt_next    = bit_cnt;
    word_next       = word;
    letter_idx_next = letter_idx;
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.letter_idx  = letter_idx;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == FUNC_NAME) begin
            cmd.start       = 1'b1;
            bit_cnt_next    = '0;
            word_next       = '0;
            letter_idx_next = '0;
            state_next      = ST_MUL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end

      // Each digit passes through a multiply state and then a correction state.
      ST_MUL: begin
        cmd.div_mul = 1'b1;
        state_next  = ST_DIV;
      end

      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + BC_W'(1);
        if (bit_cnt == BC_W'(CHUNKS - 1)) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_MUL;
        end
      end

      ST_READ: begin
        cmd.rd          = 1'b1;
        letter_idx_next = '0;
        state_next      = (word == 2'd0) ? ST_LET : ST_SEP;
      end

      // The separator ends the name when the third word is empty.
      ST_SEP: begin
        if (sts.out_free) begin
          cmd.emit_sep = 1'b1;
          cmd.last     = (word == LAST_WORD) && sts.letter_zero;
          state_next   = ST_LET;
        end
      end

      ST_LET: begin
        if (word_end) begin
          if (word == LAST_WORD) begin
            state_next = ST_IDLE;
          end else begin
            word_next    = word + 2'd1;
            bit_cnt_next = '0;
            cmd.clr_rem  = 1'b1;
            state_next   = ST_MUL;
          end
        end else if (sts.out_free) begin
          cmd.emit_letter = 1'b1;
          cmd.last        = (word == LAST_WORD) && sts.next_zero;
          letter_idx_next = letter_idx + LETTER_IDX_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Only three words make up a name.
  `ASSERT_NEVER(a_word_range, word == 2'd3, "word counter beyond the third word")

endmodule

FILE: hw/rtl/hash_to_word_triple_name.sv
// Top level of the word-triple name generator.
// Instantiates htwt_ctrl and htwt_dp; types and constants come from htwt_pkg.

// A load item (tuser 0) writes one dictionary entry; indexes of DICT_WORDS or
// more are dropped. A name request (tuser 1) splits the hash into three
// base-DICT_WORDS digits. The divider works on 16 hash bits at a time, each
// through a reciprocal multiply step and a correction step. Each word then takes
// a dictionary read, a separator before the second and third words, its letters
// and a step that closes the word. Separator and letters wait while the output
// side stalls, and no new item is accepted until the request is finished.
// Characters leave through an output register, so the next item is accepted
// while the last character still waits.
// A dictionary entry must be loaded before a name request reads it.

module hash_to_word_triple_name import htwt_pkg::*; #(
  parameter int DICT_WORDS   = 54413,
  parameter int WORD_LETTERS = 12,
  parameter int HASH_BITS    = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] entry_index, [75:16] entry_code, [123:76] request hash, [127:124] zero
  input  logic [127:0] s_tdata,
  // [0] func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] name_char
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  cmd_t    cmd;
  status_t sts;

  // Sequencer for divide, read and output steps.
  htwt_ctrl #(
    .WORD_LETTERS(WORD_LETTERS),
    .HASH_BITS   (HASH_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Dictionary, divider and output register.
  htwt_dp #(
    .DICT_WORDS  (DICT_WORDS),
    .WORD_LETTERS(WORD_LETTERS),
    .HASH_BITS   (HASH_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule
